// ===== src/ncrp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ncrp_pkg: shared types and codes for the refcounted palette allocator
// Item kinds, result status codes and sequencer states.
// ----------------------------------------------------------------------------
package ncrp_pkg;

    typedef enum logic [1:0] {
        KIND_GET  = 2'd0,
        KIND_FREE = 2'd1,
        KIND_READ = 2'd2,
        KIND_LOAD = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_EXACT  = 3'd0,
        ST_ALLOC  = 3'd1,
        ST_APPROX = 3'd2,
        ST_DONE   = 3'd3,
        ST_RANGE  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BASE,
        S_BASE_END,
        S_EXT,
        S_EXT_END,
        S_DECIDE,
        S_FINAL,
        S_FREE,
        S_READ,
        S_OUT
    } state_t;

    localparam int unsigned REG_BASE_COUNT = 0;
    localparam int unsigned REG_EXT_LIMIT  = 1;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

endpackage
`default_nettype wire

// ===== src/nearest_color_refcounted_palette.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_color_refcounted_palette: nearest-color allocator
// Base palette plus reference-counted extended palette, one item at a time.
// ----------------------------------------------------------------------------
// A get item walks the base entries in use, one per cycle through a single
// distance unit, then the extended entries below the high-water mark, one per
// cycle; an exact base hit or an empty extended table skips the extended walk.
// After reset a clearing pass zeroes the reference counts
// before the first item is taken.
// Palette memories are single-port RAMs with registered reads.
module nearest_color_refcounted_palette #(
    parameter int BASE_DEPTH = 256,
    parameter int EXT_DEPTH  = 512
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // red[7:0], green[15:8], blue[23:16], index[33:24]
    input  wire logic [1:0]  s_tuser,  // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,  // color_index, out_red, out_green, out_blue
    output logic [2:0]       m_tuser,  // status
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import ncrp_pkg::*;

    localparam int BA = $clog2(BASE_DEPTH);
    localparam int EA = $clog2(EXT_DEPTH);
    localparam int CW = 11;

    state_t state_reg, state_next;
    logic [8:0]  base_count_reg;
    logic [9:0]  ext_limit_reg;
    logic [EA:0] hw_reg;
    logic        clr_reg;
    logic [EA:0] clr_cnt_reg;

    logic [1:0]  kind_reg;
    logic [23:0] rgb_reg;
    logic [9:0]  idx_reg;
    logic [CW-1:0] nb, hw_c, lim;

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] best_reg;
    logic [18:0]   bestd_reg;
    logic          bsrc_ext_reg;   // candidate comes from the ext stream
    logic          cand_v_reg;
    logic [CW-1:0] cand_idx_reg;
    logic          cand_d1_reg;
    logic [CW-1:0] cand_idx_d1_reg;
    logic          live_d1_reg;
    logic          have_free_reg;
    logic [CW-1:0] free_reg;

    logic [9:0]  o_idx_reg;
    logic [23:0] o_rgb_reg;
    logic [2:0]  o_st_reg;

    logic          b_we, e_we, c_we;
    logic [BA-1:0] b_addr;
    logic [EA-1:0] e_addr, c_addr;
    logic [23:0]   b_wd, e_wd, b_rd, e_rd;
    logic [15:0]   c_wd, c_rd;
    logic [23:0]   dist_in;
    logic [17:0]   sq_dist;

    ncrp_ram #(.WIDTH(24), .DEPTH(BASE_DEPTH)) u_base (
        .aclk(aclk), .we(b_we), .addr(b_addr), .wdata(b_wd), .rdata(b_rd));
    ncrp_ram #(.WIDTH(24), .DEPTH(EXT_DEPTH)) u_ext (
        .aclk(aclk), .we(e_we), .addr(e_addr), .wdata(e_wd), .rdata(e_rd));
    ncrp_ram #(.WIDTH(16), .DEPTH(EXT_DEPTH)) u_cnt (
        .aclk(aclk), .we(c_we), .addr(c_addr), .wdata(c_wd), .rdata(c_rd));
    ncrp_dist u_dist (.aclk(aclk), .rgb_a(dist_in), .rgb_b(rgb_reg), .sq_dist(sq_dist));

    always_comb begin
        nb = CW'(base_count_reg);
        if (nb == '0) nb = CW'(1);
        if (nb > CW'(BASE_DEPTH)) nb = CW'(BASE_DEPTH);
        hw_c = CW'(hw_reg);
        lim  = (CW'(ext_limit_reg) > CW'(EXT_DEPTH)) ? CW'(EXT_DEPTH) : CW'(ext_limit_reg);
    end

    // candidate pipeline: address issued at cnt, data and live bit next cycle,
    // distance in the cycle after that
    assign dist_in = cand_v_reg && bsrc_ext_reg ? e_rd : b_rd;

    logic wr_cfg;
    assign wr_cfg = psel && penable && pwrite;
    assign pready = 1'b1;
    always_comb begin
        case (paddr[2])
            1'b0:    prdata = {23'd0, base_count_reg};
            default: prdata = {22'd0, ext_limit_reg};
        endcase
    end

    logic s_acc;
    assign s_tready = (state_reg == S_IDLE) && !clr_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {6'd0, o_rgb_reg[7:0], o_rgb_reg[15:8], o_rgb_reg[23:16], o_idx_reg};
    assign m_tuser  = o_st_reg;

    logic better;
    assign better = {1'b0, sq_dist} < bestd_reg;

    logic [CW-1:0] eidx, ridx;
    assign eidx = CW'(idx_reg) - nb;
    assign ridx = CW'(idx_reg);

    // memory port control
    always_comb begin
        b_we = 1'b0; e_we = 1'b0; c_we = 1'b0;
        b_addr = BA'(cnt_reg); e_addr = EA'(cnt_reg); c_addr = EA'(cnt_reg);
        b_wd = rgb_reg; e_wd = rgb_reg; c_wd = 16'd0;
        if (clr_reg) begin
            c_we = 1'b1; c_addr = EA'(clr_cnt_reg);
        end
        case (state_reg)
            S_IDLE: begin
                if (s_acc && s_tuser == KIND_LOAD
                    && CW'(s_tdata[33:24]) < CW'(BASE_DEPTH)) begin
                    b_we = 1'b1; b_addr = BA'(s_tdata[33:24]);
                    b_wd = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
                end
            end
            S_DECIDE: begin
                e_addr = EA'(free_reg); c_addr = EA'(free_reg);
                b_addr = BA'(best_reg);
                if (!bsrc_ext_reg && bestd_reg != '0 && free_reg < lim
                    && free_reg < CW'(EXT_DEPTH)) begin
                    e_we = 1'b1; c_we = 1'b1; c_wd = 16'd1;
                end else if (best_reg >= nb) begin
                    e_addr = EA'(best_reg - nb); c_addr = EA'(best_reg - nb);
                end
            end
            S_FINAL: begin
                c_addr = EA'(best_reg - nb);
                if (o_st_reg != ST_ALLOC && best_reg >= nb && c_rd != COUNT_MAX) begin
                    c_we = 1'b1; c_wd = c_rd + 16'd1;
                end
            end
            S_FREE: begin
                c_addr = EA'(eidx);
                // out-of-range read falls back to base entry 1
                b_addr = (ridx < nb) ? BA'(ridx) : BA'(1);
                e_addr = EA'(eidx);
            end
            S_READ: begin
                c_addr = EA'(eidx);
                if (kind_reg == KIND_FREE && ridx >= nb && ridx < nb + hw_c
                    && c_rd != 16'd0) begin
                    c_we = 1'b1; c_wd = c_rd - 16'd1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_acc) begin
                case (s_tuser)
                    KIND_GET: state_next = S_BASE;
                    KIND_LOAD: state_next = S_OUT;
                    default:  state_next = S_FREE;
                endcase
            end
            S_BASE:     if (cnt_reg == nb - CW'(1)) state_next = S_BASE_END;
            S_BASE_END: if (!cand_v_reg && !cand_d1_reg) state_next = S_EXT;
            S_EXT:      if (cnt_reg >= hw_c) state_next = S_EXT_END;
            S_EXT_END:  if (!cand_v_reg && !cand_d1_reg) state_next = S_DECIDE;
            S_DECIDE:   state_next = S_FINAL;
            S_FINAL:    state_next = S_OUT;
            S_FREE:     state_next = S_READ;
            S_READ:     state_next = S_OUT;
            S_OUT:      if (m_tready) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            base_count_reg <= 9'd256;
            ext_limit_reg  <= 10'd512;
            hw_reg         <= '0;
            clr_reg        <= 1'b1;
            clr_cnt_reg    <= '0;
            cand_v_reg     <= 1'b0;
            cand_d1_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (wr_cfg && paddr == 3'(4 * REG_BASE_COUNT)) base_count_reg <= pwdata[8:0];
            if (wr_cfg && paddr == 3'(4 * REG_EXT_LIMIT))  ext_limit_reg  <= pwdata[9:0];
            if (clr_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == (EA+1)'(EXT_DEPTH - 1)) clr_reg <= 1'b0;
            end
            cand_v_reg  <= (state_reg == S_BASE) || (state_reg == S_EXT && cnt_reg < hw_c);
            cand_d1_reg <= cand_v_reg;
            if (state_reg == S_DECIDE && !bsrc_ext_reg && bestd_reg != '0
                && free_reg < lim && free_reg < CW'(EXT_DEPTH) && free_reg == hw_c) begin
                hw_reg <= hw_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cand_idx_reg    <= cnt_reg;
        cand_idx_d1_reg <= cand_idx_reg;
        live_d1_reg     <= cand_v_reg && (!bsrc_ext_reg || c_rd != 16'd0);
        case (state_reg)
            S_IDLE: begin
                kind_reg  <= s_tuser;
                rgb_reg   <= {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
                idx_reg   <= s_tdata[33:24];
                cnt_reg   <= '0;
                bestd_reg <= '1;
                best_reg  <= '0;
                bsrc_ext_reg  <= 1'b0;
                have_free_reg <= 1'b0;
                o_idx_reg <= s_tdata[33:24];
                o_rgb_reg <= '0;
                o_st_reg  <= (CW'(s_tdata[33:24]) < CW'(BASE_DEPTH)) ? ST_DONE : ST_RANGE;
            end
            S_BASE: cnt_reg <= cnt_reg + CW'(1);
            S_BASE_END: if (!cand_v_reg && !cand_d1_reg) begin
                // exact base hit: skip the extended pass
                cnt_reg <= (bestd_reg == '0) ? hw_c : '0;
                free_reg <= hw_c;
                bsrc_ext_reg <= 1'b1;
            end
            S_EXT: if (cnt_reg < hw_c) cnt_reg <= cnt_reg + CW'(1);
            S_EXT_END: if (!cand_v_reg && !cand_d1_reg) bsrc_ext_reg <= 1'b0;
            S_DECIDE: begin
                if (bestd_reg != '0 && free_reg < lim && free_reg < CW'(EXT_DEPTH)) begin
                    o_st_reg  <= ST_ALLOC;
                    o_idx_reg <= 10'(nb + free_reg);
                    o_rgb_reg <= rgb_reg;
                end else begin
                    o_st_reg  <= (bestd_reg == '0) ? ST_EXACT : ST_APPROX;
                    o_idx_reg <= 10'(best_reg);
                end
            end
            S_FINAL: begin
                if (o_st_reg != ST_ALLOC) o_rgb_reg <= (best_reg >= nb) ? e_rd : b_rd;
            end
            S_READ: begin
                if (kind_reg == KIND_FREE) begin
                    o_st_reg <= (ridx >= nb && ridx < nb + hw_c) ? ST_DONE : ST_RANGE;
                end else if (ridx < nb) begin
                    o_rgb_reg <= b_rd; o_st_reg <= ST_DONE;
                end else if (ridx < nb + hw_c) begin
                    o_rgb_reg <= e_rd; o_st_reg <= ST_DONE;
                end else begin
                    o_idx_reg <= 10'd1; o_rgb_reg <= b_rd; o_st_reg <= ST_RANGE;
                end
            end
            default: ;
        endcase
        // distance arrives through the RAM read register and the distance register
        if (cand_d1_reg && live_d1_reg && better) begin
            bestd_reg <= {1'b0, sq_dist};
            best_reg  <= bsrc_ext_reg ? nb + cand_idx_d1_reg : cand_idx_d1_reg;
        end
        if (cand_v_reg && bsrc_ext_reg && c_rd == 16'd0 && !have_free_reg
            && (state_reg == S_EXT || state_reg == S_EXT_END)) begin
            have_free_reg <= 1'b1;
            free_reg      <= cand_idx_reg;
        end
    end

    logic unused;
    assign unused = ^{s_tdata[39:34], pwdata[31:10], paddr[1:0]};
endmodule
`default_nettype wire

// ===== src/ncrp_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ncrp_ram: generic single-port RAM
// One address per cycle, written if we is set and always read; registered read data.
// ----------------------------------------------------------------------------
module ncrp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ===== src/ncrp_dist.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ncrp_dist: squared RGB distance unit
// Three 9-bit differences squared and summed, registered.
// ----------------------------------------------------------------------------
module ncrp_dist (
    input  wire logic        aclk,
    input  wire logic [23:0] rgb_a,
    input  wire logic [23:0] rgb_b,
    output logic      [17:0] sq_dist
);
    logic signed [8:0]  dr, dg, db;
    logic        [17:0] sum;

    always_comb begin
        dr  = $signed({1'b0, rgb_a[23:16]}) - $signed({1'b0, rgb_b[23:16]});
        dg  = $signed({1'b0, rgb_a[15:8]})  - $signed({1'b0, rgb_b[15:8]});
        db  = $signed({1'b0, rgb_a[7:0]})   - $signed({1'b0, rgb_b[7:0]});
        sum = 18'(unsigned'(16'(dr * dr))) + 18'(unsigned'(16'(dg * dg)))
            + 18'(unsigned'(16'(db * db)));
    end

    always_ff @(posedge aclk) begin
        sq_dist <= sum;
    end
endmodule
`default_nettype wire

// ===== src/ncrp_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ncrp_checker: port-level checks for the palette allocator
// Handshake and sequencing properties seen from the ports.
// ----------------------------------------------------------------------------
module ncrp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [2:0]  m_tuser,
    input wire logic        pready
);
    // one item in flight: no input taken while a result waits
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input ready while result pending");
    // an accepted item shuts the input
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("ready after accept");
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result dropped under stall");
    a_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= 3'd4)) else $error("bad status");
    a_pready: assert property (@(posedge aclk) pready) else $error("pready low");
endmodule

bind nearest_color_refcounted_palette ncrp_checker u_ncrp_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .pready(pready));
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the refcounted nearest-color palette allocator
// Drives load, get, free and read items over the input stream, predicts each
// result from a shadow copy of both palettes, the counts and the registers,
// and checks every result field by field. Several register settings are run.
// ----------------------------------------------------------------------------
module tb_top;
    import ncrp_pkg::*;

    typedef struct {
        logic [9:0] cidx;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        status_t    st;
    } answer_t;

    typedef struct {
        kind_t      kind;
        logic [23:0] rgb;
        logic [9:0] idx;
        bit         typed;
        answer_t    ans;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    nearest_color_refcounted_palette u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow state
    logic [23:0] base_pal [256];
    logic [23:0] ext_pal  [512];
    logic [15:0] ext_cnt  [512];
    bit          base_written [256];
    int unsigned high_water;
    int unsigned base_reg;
    int unsigned limit_reg;

    answer_t pending_answers[$];
    int      errors = 0;
    int      rx_count = 0;
    int      cycles = 0;
    bit      calm = 1'b0;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 5000000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int unsigned eff_base();
        if (base_reg < 1) return 1;
        if (base_reg > 256) return 256;
        return base_reg;
    endfunction

    function automatic int unsigned color_dist(logic [23:0] rgb, logic [23:0] want);
        int dr, dg, db;
        dr = int'(rgb[23:16]) - int'(want[23:16]);
        dg = int'(rgb[15:8]) - int'(want[15:8]);
        db = int'(rgb[7:0]) - int'(want[7:0]);
        return dr * dr + dg * dg + db * db;
    endfunction

    function automatic answer_t make_answer(int unsigned idx, logic [23:0] rgb, status_t st);
        answer_t a;
        a.cidx = idx[9:0];
        a.red = rgb[23:16];
        a.green = rgb[15:8];
        a.blue = rgb[7:0];
        a.st = st;
        return a;
    endfunction

    // Advance the shadow state by one item and return the result it causes.
    function automatic answer_t predict_palette(kind_t kind, logic [23:0] rgb, logic [9:0] idx);
        int unsigned nb, hw, lim, best, bestd, d, freeslot, e, i;
        bit have_free;
        nb = eff_base();
        hw = high_water;
        case (kind)
            KIND_GET: begin
                best = 0;
                bestd = 32'hFFFF_FFFF;
                for (i = 0; i < nb; i++) begin
                    d = color_dist(base_pal[i], rgb);
                    if (d < bestd) begin
                        best = i;
                        bestd = d;
                    end
                end
                if (bestd == 0) return make_answer(best, base_pal[best], ST_EXACT);
                lim = (limit_reg > 512) ? 512 : limit_reg;
                freeslot = hw;
                have_free = 1'b0;
                for (i = 0; i < hw; i++) begin
                    if (ext_cnt[i] > 0) begin
                        d = color_dist(ext_pal[i], rgb);
                        if (d < bestd) begin
                            best = nb + i;
                            bestd = d;
                        end
                    end else if (!have_free) begin
                        have_free = 1'b1;
                        freeslot = i;
                    end
                end
                if (bestd != 0 && freeslot < lim && freeslot < 512) begin
                    ext_pal[freeslot] = rgb;
                    ext_cnt[freeslot] = 16'd1;
                    if (freeslot == hw) high_water = hw + 1;
                    return make_answer(nb + freeslot, rgb, ST_ALLOC);
                end
                if (best >= nb) begin
                    e = best - nb;
                    if (ext_cnt[e] != COUNT_MAX) ext_cnt[e] = ext_cnt[e] + 1;
                    return make_answer(best, ext_pal[e], (bestd == 0) ? ST_EXACT : ST_APPROX);
                end
                return make_answer(best, base_pal[best], ST_APPROX);
            end
            KIND_FREE: begin
                if (idx >= nb && idx < nb + hw) begin
                    e = idx - nb;
                    if (ext_cnt[e] > 0) ext_cnt[e] = ext_cnt[e] - 1;
                    return make_answer(idx, 24'h0, ST_DONE);
                end
                return make_answer(idx, 24'h0, ST_RANGE);
            end
            KIND_READ: begin
                if (idx < nb) return make_answer(idx, base_pal[idx], ST_DONE);
                if (idx < nb + hw) return make_answer(idx, ext_pal[idx - nb], ST_DONE);
                return make_answer(1, base_pal[1], ST_RANGE);
            end
            default: begin
                if (idx < 256) begin
                    base_pal[idx] = rgb;
                    base_written[idx] = 1'b1;
                    return make_answer(idx, 24'h0, ST_DONE);
                end
                return make_answer(idx, 24'h0, ST_RANGE);
            end
        endcase
    endfunction

    // Offer one item; on acceptance update the shadow state and queue the answer.
    task automatic send_item(kind_t kind, logic [23:0] rgb, logic [9:0] idx,
                             bit typed, answer_t typed_ans);
        answer_t a;
        @(negedge aclk);
        while (!calm && $urandom_range(0, 99) < 31) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {6'b0, idx, rgb[7:0], rgb[15:8], rgb[23:16]};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        a = predict_palette(kind, rgb, idx);
        pending_answers.push_back(typed ? typed_ans : a);
    endtask

    task automatic apb_write(int unsigned reg_idx, int unsigned value);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(reg_idx * 4);
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_idx == REG_BASE_COUNT) base_reg = value & 32'h1FF;
        else limit_reg = value & 32'h3FF;
    endtask

    task automatic configure(int unsigned nbase, int unsigned lim);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending_answers.size() == 0);
        repeat (20) @(posedge aclk);
        apb_write(REG_BASE_COUNT, nbase);
        apb_write(REG_EXT_LIMIT, lim);
    endtask

    // result checker
    always @(posedge aclk) begin
        answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            rx_count <= rx_count + 1;
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result %h status %0d", $time, m_tdata, m_tuser);
                errors <= errors + 1;
            end else begin
                want = pending_answers.pop_front();
                if (m_tdata[9:0] !== want.cidx || m_tdata[17:10] !== want.red ||
                    m_tdata[25:18] !== want.green || m_tdata[33:26] !== want.blue ||
                    m_tuser !== want.st) begin
                    $display({"%0t: mismatch expected idx %0d rgb %h%h%h st %0d,",
                              " got idx %0d rgb %h%h%h st %0d"},
                             $time, want.cidx, want.red, want.green, want.blue, want.st,
                             m_tdata[9:0], m_tdata[17:10], m_tdata[25:18], m_tdata[33:26],
                             m_tuser);
                    errors <= errors + 1;
                end
            end
        end
    end

    // receiver: random stalls, plus one long hold-off to back the block up
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && rx_count == 40) begin
            m_tready <= 1'b0;
            hold_left <= 400;
            hold_done <= 1'b1;
        end else if (!calm && $urandom_range(0, 99) < 31) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic [23:0] pick_color(const ref logic [23:0] pool[16]);
        if ($urandom_range(0, 1)) return pool[$urandom_range(0, 15)];
        return 24'($urandom);
    endfunction

    function automatic answer_t ans(int unsigned idx, logic [23:0] rgb, status_t st);
        return make_answer(idx, rgb, st);
    endfunction

    row_t directed[$];
    logic [23:0] pool[16];
    int unsigned phase_base[6] = '{4, 0, 8, 256, 511, 16};
    int unsigned phase_limit[6] = '{3, 0, 1, 512, 1023, 20};

    task automatic fill_base();
        int unsigned i;
        answer_t none;
        for (i = 0; i < eff_base(); i++)
            if (!base_written[i]) send_item(KIND_LOAD, pick_color(pool), 10'(i), 1'b0, none);
    endtask

    task automatic random_items(int unsigned count);
        int unsigned n, nb, r, idx;
        kind_t k;
        answer_t none;
        n = 0;
        while (n < count) begin
            nb = eff_base();
            r = $urandom_range(0, 99);
            if (r < 45) begin
                k = KIND_GET;
                idx = $urandom_range(0, 1023);
            end else if (r < 65) begin
                k = KIND_FREE;
                idx = $urandom_range(0, 9) == 0 ? $urandom_range(0, 1023)
                                                : $urandom_range(nb, nb + high_water + 2);
            end else if (r < 85) begin
                k = KIND_READ;
                idx = $urandom_range(0, 9) == 0 ? $urandom_range(0, 1023)
                                                : $urandom_range(0, nb + high_water + 2);
            end else begin
                k = KIND_LOAD;
                idx = $urandom_range(0, 9) == 0 ? $urandom_range(0, 1023)
                                                : $urandom_range(0, 255);
            end
            // never read a base entry that was never loaded
            if (k == KIND_READ && idx < nb && !base_written[idx]) continue;
            send_item(k, pick_color(pool), 10'(idx), 1'b0, none);
            n++;
        end
    endtask

    initial begin
        int unsigned p, i;
        answer_t none;
        for (i = 0; i < 256; i++) begin
            base_pal[i] = '0;
            base_written[i] = 1'b0;
        end
        for (i = 0; i < 512; i++) begin
            ext_pal[i] = '0;
            ext_cnt[i] = '0;
        end
        high_water = 0;
        base_reg = 256;
        limit_reg = 512;
        for (i = 0; i < 16; i++) pool[i] = 24'($urandom);
        pool[0] = 24'h000000;
        pool[1] = 24'hFFFFFF;

        directed = '{
            '{KIND_LOAD, 24'h000000, 10'd0,    1, ans(0, 0, ST_DONE)},
            '{KIND_LOAD, 24'hFFFFFF, 10'd1,    1, ans(1, 0, ST_DONE)},
            '{KIND_LOAD, 24'h804020, 10'd2,    1, ans(2, 0, ST_DONE)},
            '{KIND_LOAD, 24'h010203, 10'd3,    1, ans(3, 0, ST_DONE)},
            '{KIND_LOAD, 24'h123456, 10'd1023, 1, ans(1023, 0, ST_RANGE)},
            '{KIND_LOAD, 24'hAA55AA, 10'd255,  1, ans(255, 0, ST_DONE)},
            '{KIND_GET,  24'h000000, 10'd0,    1, ans(0, 24'h000000, ST_EXACT)},
            '{KIND_GET,  24'hFFFFFF, 10'd1023, 1, ans(1, 24'hFFFFFF, ST_EXACT)},
            '{KIND_GET,  24'h101010, 10'd0,    1, ans(4, 24'h101010, ST_ALLOC)},
            '{KIND_GET,  24'h101010, 10'd0,    1, ans(4, 24'h101010, ST_EXACT)},
            '{KIND_GET,  24'hF00000, 10'd0,    1, ans(5, 24'hF00000, ST_ALLOC)},
            '{KIND_GET,  24'h00F000, 10'd0,    1, ans(6, 24'h00F000, ST_ALLOC)},
            '{KIND_GET,  24'h0000F0, 10'd0,    0, none},
            '{KIND_READ, 24'h000000, 10'd1,    1, ans(1, 24'hFFFFFF, ST_DONE)},
            '{KIND_READ, 24'h000000, 10'd5,    1, ans(5, 24'hF00000, ST_DONE)},
            '{KIND_READ, 24'h000000, 10'd7,    1, ans(1, 24'hFFFFFF, ST_RANGE)},
            '{KIND_READ, 24'hFFFFFF, 10'd1023, 1, ans(1, 24'hFFFFFF, ST_RANGE)},
            '{KIND_FREE, 24'h000000, 10'd5,    1, ans(5, 0, ST_DONE)},
            '{KIND_FREE, 24'h000000, 10'd5,    1, ans(5, 0, ST_DONE)},
            '{KIND_FREE, 24'h000000, 10'd2,    1, ans(2, 0, ST_RANGE)},
            '{KIND_FREE, 24'hFFFFFF, 10'd1023, 1, ans(1023, 0, ST_RANGE)},
            '{KIND_GET,  24'hF10000, 10'd0,    1, ans(5, 24'hF10000, ST_ALLOC)},
            '{KIND_GET,  24'h0000F0, 10'd0,    0, none}
        };

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        configure(phase_base[0], phase_limit[0]);
        foreach (directed[j])
            send_item(directed[j].kind, directed[j].rgb, directed[j].idx,
                      directed[j].typed, directed[j].ans);

        for (p = 0; p < 6; p++) begin
            if (p > 0) configure(phase_base[p], phase_limit[p]);
            calm = (p == 2);
            fill_base();
            random_items(p == 3 ? 60 : 90);
        end
        calm = 1'b0;

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending_answers.size() == 0);
        repeat (50) @(posedge aclk);
        if (errors == 0 && pending_answers.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/ncrp_pkg.sv
src/ncrp_ram.sv
src/ncrp_dist.sv
src/nearest_color_refcounted_palette.sv
src/ncrp_checker.sv
sim/tb_top.sv
